/* hw/rtl/rtlpm_pkg.sv */
// Shared types, constants and helpers for the route table with longest-prefix match.
// No dependencies; imported by the interfaces, rtlpm_scan and route_table_lpm.
package rtlpm_pkg;

  localparam int IP_W            = 32;
  localparam int LEN_W           = 6;
  localparam int MAX_LEN         = 32;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int IFACE_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SAME      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Findings of one pass over the table
  typedef struct packed {
    logic exact_found;
    logic exact_same;
    logic free_found;
    logic best_found;
  } scan_flags_t;

  // Network mask for a prefix length; lengths above the maximum give all ones
  function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({IP_W{1'b1}} >> len);
  endfunction

  // Clamp a prefix length to the address width
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
  endfunction

endpackage

/* hw/rtl/rtlpm_req_if.sv */
// Request channel of the route table: valid/ready handshake and operation payload.
// Depends on rtlpm_pkg for the field widths.
interface rtlpm_req_if #(
  parameter int IFACE_BITS = rtlpm_pkg::IFACE_BITS_DEF
);
  import rtlpm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [IP_W-1:0]       dest_ip;
  logic [LEN_W-1:0]      prefix_len;
  logic [IP_W-1:0]       gateway_ip;
  logic [IFACE_BITS-1:0] out_interface;
  logic                  direct_route;

  modport source (
    output valid, op, dest_ip, prefix_len, gateway_ip, out_interface, direct_route,
    input  ready
  );

  modport sink (
    input  valid, op, dest_ip, prefix_len, gateway_ip, out_interface, direct_route,
    output ready
  );
endinterface

/* hw/rtl/rtlpm_rsp_if.sv */
// Response channel of the route table: valid/ready handshake and result payload.
// Depends on rtlpm_pkg for the field widths.
interface rtlpm_rsp_if #(
  parameter int IFACE_BITS = rtlpm_pkg::IFACE_BITS_DEF
);
  import rtlpm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  hit;
  logic [IP_W-1:0]       next_hop;
  logic [IFACE_BITS-1:0] egress_if;
  logic                  hit_direct;
  logic [LEN_W-1:0]      match_len;

  modport source (
    output valid, status, hit, next_hop, egress_if, hit_direct, match_len,
    input  ready
  );

  modport sink (
    input  valid, status, hit, next_hop, egress_if, hit_direct, match_len,
    output ready
  );
endinterface

/* hw/rtl/rtlpm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rtlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, with the read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rtlpm_scan.sv */
// Per-entry evaluation for one pass over the table: exact match, first free slot and
// longest matching prefix. Depends on rtlpm_pkg.
module rtlpm_scan #(
  parameter int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH_DEF,
  parameter int IFACE_BITS  = rtlpm_pkg::IFACE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                ent_vld,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      ent_idx,
  input  logic                                e_valid,
  input  logic [rtlpm_pkg::IP_W-1:0]          e_prefix,
  input  logic [rtlpm_pkg::LEN_W-1:0]         e_len,
  input  logic [rtlpm_pkg::IP_W-1:0]          e_gw,
  input  logic [IFACE_BITS-1:0]               e_if,
  input  logic                                e_dir,
  input  rtlpm_pkg::op_t                      key_op,
  input  logic [rtlpm_pkg::IP_W-1:0]          key_prefix,
  input  logic [rtlpm_pkg::LEN_W-1:0]         key_len,
  input  logic [rtlpm_pkg::IP_W-1:0]          key_dip,
  input  logic [rtlpm_pkg::IP_W-1:0]          key_gw,
  input  logic [IFACE_BITS-1:0]               key_if,
  input  logic                                key_dir,
  output rtlpm_pkg::scan_flags_t              flags,
  output logic [$clog2(TABLE_DEPTH)-1:0]      exact_slot,
  output logic [$clog2(TABLE_DEPTH)-1:0]      free_slot,
  output logic [rtlpm_pkg::LEN_W-1:0]         best_len,
  output logic [rtlpm_pkg::IP_W-1:0]          best_gw,
  output logic [IFACE_BITS-1:0]               best_if,
  output logic                                best_dir
);
  import rtlpm_pkg::*;

  logic hit_exact;
  logic same_body;
  logic route_match;
  logic better;

  // Compare the returning entry against the key
  assign hit_exact   = e_valid && (e_prefix == key_prefix) && (e_len == key_len);
  assign same_body   = (e_gw == key_gw) && (e_if == key_if) && (e_dir == key_dir);
  assign route_match = e_valid && ((key_dip & len_mask(e_len)) == e_prefix);
  assign better      = !flags.best_found || (e_len > best_len);

  // Record the first exact match, the first free slot and, for a lookup, the longest match
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (ent_vld) begin
      if (hit_exact && !flags.exact_found) begin
        flags.exact_found <= 1'b1;
        flags.exact_same  <= same_body;
        exact_slot        <= ent_idx;
      end
      if (!e_valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
        free_slot        <= ent_idx;
      end
      if (key_op == OP_LOOKUP && route_match && better) begin
        flags.best_found <= 1'b1;
        best_len         <= e_len;
        best_gw          <= e_gw;
        best_if          <= e_if;
        best_dir         <= e_dir;
      end
    end
  end

endmodule

/* hw/rtl/route_table_lpm.sv */
// Route table with longest-prefix match: sequencer, table memory and output register.
// Depends on rtlpm_pkg, rtlpm_req_if, rtlpm_rsp_if, rtlpm_ram and rtlpm_scan.
//
// Usage: one operation per transfer on req (add, delete, lookup, clear); exactly one
// result per operation on rsp. Both channels use valid/ready; a transfer happens at a
// rising edge with valid and ready high.
// Add, delete and lookup read every table slot once, one slot per cycle from the
// single table memory, then write back any change in S_FINISH and load the result in
// S_DONE; clear writes every slot once before its result is loaded.
// Operations run one at a time; req.ready is high only while no operation is active,
// so a new request is taken only once the previous operation has loaded its result.
// The result sits in an output register, so the next request is taken while an
// earlier result still waits; if the receiver stalls with a result pending, a
// finished operation holds in its last state until the register frees.
// Reset (synchronous, active high) starts a clearing pass over the table memory,
// during which req.ready stays low and no result is produced.
module route_table_lpm #(
  parameter int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH_DEF,
  parameter int IFACE_BITS  = rtlpm_pkg::IFACE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rtlpm_req_if.sink   req,
  rtlpm_rsp_if.source rsp
);
  import rtlpm_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic                  valid;
    logic [IP_W-1:0]       prefix;
    logic [LEN_W-1:0]      len;
    logic [IP_W-1:0]       gw;
    logic [IFACE_BITS-1:0] ifc;
    logic                  dir;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic                  clr_reply;
  logic                  rd_pend;
  logic [ADDR_W-1:0]     rd_idx;

  op_t                   op_q;
  logic [IP_W-1:0]       prefix_q;
  logic [LEN_W-1:0]      len_q;
  logic [IP_W-1:0]       dip_q;
  logic [IP_W-1:0]       gw_q;
  logic [IFACE_BITS-1:0] if_q;
  logic                  dir_q;

  logic                  in_acc;
  logic                  issue;
  logic                  rsp_load;
  logic [LEN_W-1:0]      req_len;
  op_t                   req_op;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  entry_t                ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_ent;
  entry_t                new_ent;

  scan_flags_t           flags;
  logic [ADDR_W-1:0]     exact_slot;
  logic [ADDR_W-1:0]     free_slot;
  logic [LEN_W-1:0]      best_len;
  logic [IP_W-1:0]       best_gw;
  logic [IFACE_BITS-1:0] best_if;
  logic                  best_dir;

  status_t               res_status;
  logic                  res_hit;

  assign req.ready = (state == S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign req_op    = op_t'(req.op);
  assign req_len   = sat_len(req.prefix_len);
  assign issue     = (state == S_SCAN) && (cnt < DEPTH_C);
  assign rsp_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign rd_ent    = entry_t'(ram_rdata);
  assign new_ent   = '{valid: 1'b1, prefix: prefix_q, len: len_q, gw: gw_q,
                       ifc: if_q, dir: dir_q};

  rtlpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  rtlpm_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IFACE_BITS  (IFACE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (in_acc),
    .ent_vld    (rd_pend),
    .ent_idx    (rd_idx),
    .e_valid    (rd_ent.valid),
    .e_prefix   (rd_ent.prefix),
    .e_len      (rd_ent.len),
    .e_gw       (rd_ent.gw),
    .e_if       (rd_ent.ifc),
    .e_dir      (rd_ent.dir),
    .key_op     (op_q),
    .key_prefix (prefix_q),
    .key_len    (len_q),
    .key_dip    (dip_q),
    .key_gw     (gw_q),
    .key_if     (if_q),
    .key_dir    (dir_q),
    .flags      (flags),
    .exact_slot (exact_slot),
    .free_slot  (free_slot),
    .best_len   (best_len),
    .best_gw    (best_gw),
    .best_if    (best_if),
    .best_dir   (best_dir)
  );

  // Table writes: clearing sweep, or the single write-back after a pass
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[ADDR_W-1:0];
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_FINISH: begin
        case (op_q)
          OP_ADD: begin
            if (flags.exact_found) begin
              ram_we    = !flags.exact_same;
              ram_waddr = exact_slot;
              ram_wdata = new_ent;
            end else begin
              ram_we    = flags.free_found;
              ram_waddr = free_slot;
              ram_wdata = new_ent;
            end
          end
          OP_DEL: begin
            ram_we    = flags.exact_found;
            ram_waddr = exact_slot;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result of the finished operation
  always_comb begin
    res_hit = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (flags.exact_found) begin
          res_status = flags.exact_same ? ST_SAME : ST_OK;
        end else begin
          res_status = flags.free_found ? ST_OK : ST_FULL;
        end
      end
      OP_DEL: begin
        res_status = flags.exact_found ? ST_OK : ST_NOT_FOUND;
      end
      OP_LOOKUP: begin
        res_hit    = flags.best_found;
        res_status = flags.best_found ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Sequencer, request key and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_reply <= 1'b0;
      rd_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_idx  <= cnt[ADDR_W-1:0];
      // Load a finished result, or drop the one just taken
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == DEPTH_C - 1'b1) begin
            cnt       <= '0;
            clr_reply <= 1'b0;
            state     <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q      <= req_op;
            prefix_q  <= req.dest_ip & len_mask(req_len);
            len_q     <= req_len;
            dip_q     <= req.dest_ip;
            gw_q      <= req.direct_route ? '0 : req.gateway_ip;
            if_q      <= req.direct_route ? '0 : req.out_interface;
            dir_q     <= req.direct_route;
            cnt       <= '0;
            clr_reply <= (req_op == OP_CLEAR);
            state     <= (req_op == OP_CLEAR) ? S_CLEAR : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end else if (!rd_pend) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.status     <= res_status;
            rsp.hit        <= res_hit;
            rsp.next_hop   <= res_hit ? best_gw : '0;
            rsp.egress_if  <= res_hit ? best_if : '0;
            rsp.hit_direct <= res_hit && best_dir;
            rsp.match_len  <= res_hit ? best_len : '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new result is only loaded out of the final state of an operation
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("result appeared outside the final state");

  // The table is never written while a pass is reading it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("table write during a scan pass");

  // An accepted request starts either a scan or a clearing sweep
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_SCAN || state == S_CLEAR))
    else $error("accepted request did not start work");

  // The pass ends only once the last entry has been evaluated
  a_scan_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == DEPTH_C && !rd_pend) |=> (state == S_FINISH))
    else $error("scan pass did not finish after the last entry");

  // The result register is not overwritten while it is stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status)))
    else $error("stalled result lost");

endmodule

/* bench/route_table_lpm_tb.sv */
// Self-checking bench for route_table_lpm: directed and random add/delete/lookup/clear
// traffic on the request channel, results checked against an in-bench route table.
// Depends on rtlpm_pkg, rtlpm_req_if, rtlpm_rsp_if and the route_table_lpm RTL.
module route_table_lpm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtlpm_pkg::*;

  localparam int DEPTH        = 64;
  localparam int IFB          = 8;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int RAND_ITEMS   = 726;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam bit TYPED        = 1'b1;
  localparam bit PREDICTED    = 1'b0;

  typedef struct packed {
    op_t              op;
    logic [IP_W-1:0]  dest;
    logic [LEN_W-1:0] plen;
    logic [IP_W-1:0]  gw;
    logic [IFB-1:0]   ifc;
    logic             dir;
  } route_req_t;

  typedef struct packed {
    status_t          status;
    logic             hit;
    logic [IP_W-1:0]  next_hop;
    logic [IFB-1:0]   egress_if;
    logic             hit_direct;
    logic [LEN_W-1:0] match_len;
  } route_rsp_t;

  typedef struct packed {
    route_req_t rq;
    bit         typed;
    status_t    status;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtlpm_req_if #(.IFACE_BITS(IFB)) req_bus ();
  rtlpm_rsp_if #(.IFACE_BITS(IFB)) rsp_bus ();

  route_table_lpm #(
    .TABLE_DEPTH(DEPTH),
    .IFACE_BITS (IFB)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Bench copy of the route table
  logic             rt_valid [DEPTH];
  logic [IP_W-1:0]  rt_pfx   [DEPTH];
  logic [LEN_W-1:0] rt_len   [DEPTH];
  logic [IP_W-1:0]  rt_gw    [DEPTH];
  logic [IFB-1:0]   rt_if    [DEPTH];
  logic             rt_dir   [DEPTH];

  route_rsp_t pending_results[$];
  plan_row_t  plan[$];

  int err_cnt      = 0;
  int ops_sent     = 0;
  int results_seen = 0;
  int cycle_cnt    = 0;
  int hit_cnt      = 0;
  int op_cnt     [4];
  int status_cnt [4];

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len == '0) return '0;
    return {IP_W{1'b1}} << (IP_W - len);
  endfunction

  // Slot holding exactly this prefix and length, or -1
  function automatic int find_route(input logic [IP_W-1:0] pfx, input logic [LEN_W-1:0] len);
    for (int i = 0; i < DEPTH; i++) begin
      if (rt_valid[i] && rt_pfx[i] == pfx && rt_len[i] == len) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the bench table and return the result it should give
  function automatic route_rsp_t route_table_apply(input route_req_t rq);
    route_rsp_t       res;
    logic [LEN_W-1:0] len;
    logic [IP_W-1:0]  pfx;
    logic [IP_W-1:0]  gw;
    logic [IFB-1:0]   ifc;
    int               slot;
    res  = '0;
    len  = (rq.plen > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : rq.plen;
    pfx  = rq.dest & prefix_mask(len);
    slot = -1;
    case (rq.op)
      OP_ADD: begin
        gw  = rq.dir ? '0 : rq.gw;
        ifc = rq.dir ? '0 : rq.ifc;
        slot = find_route(pfx, len);
        if (slot >= 0) begin
          if (rt_gw[slot] == gw && rt_if[slot] == ifc && rt_dir[slot] == rq.dir) begin
            res.status = ST_SAME;
          end else begin
            rt_gw[slot]  = gw;
            rt_if[slot]  = ifc;
            rt_dir[slot] = rq.dir;
          end
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!rt_valid[i]) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            rt_valid[slot] = 1'b1;
            rt_pfx[slot]   = pfx;
            rt_len[slot]   = len;
            rt_gw[slot]    = gw;
            rt_if[slot]    = ifc;
            rt_dir[slot]   = rq.dir;
          end
        end
      end
      OP_DEL: begin
        slot = find_route(pfx, len);
        if (slot >= 0) rt_valid[slot] = 1'b0;
        else res.status = ST_NOT_FOUND;
      end
      OP_LOOKUP: begin
        // Longest covering prefix wins; the default route covers everything
        for (int i = 0; i < DEPTH; i++) begin
          if (rt_valid[i] && (rq.dest & prefix_mask(rt_len[i])) == rt_pfx[i] &&
              (slot < 0 || rt_len[i] > rt_len[slot])) slot = i;
        end
        if (slot >= 0) begin
          res.hit        = 1'b1;
          res.next_hop   = rt_gw[slot];
          res.egress_if  = rt_if[slot];
          res.hit_direct = rt_dir[slot];
          res.match_len  = rt_len[slot];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) rt_valid[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Random stored route, or -1 when the table is empty
  function automatic int pick_route();
    int idx[$];
    for (int i = 0; i < DEPTH; i++) begin
      if (rt_valid[i]) idx.push_back(i);
    end
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  function automatic logic [LEN_W-1:0] draw_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return '0;
    if (p < 15) return LEN_W'(MAX_LEN);
    if (p < 25) return LEN_W'($urandom_range(MAX_LEN + 1, 63));
    return LEN_W'($urandom_range(1, MAX_LEN - 1));
  endfunction

  // Filling mode is add-heavy so the table runs full; mixed mode revisits stored routes
  function automatic route_req_t draw_request(input bit filling);
    route_req_t  rq;
    int unsigned p;
    int unsigned coin;
    int          s;
    p       = $urandom_range(0, 99);
    coin    = $urandom_range(0, 99);
    s       = pick_route();
    rq.op   = OP_LOOKUP;
    rq.dest = $urandom();
    rq.plen = draw_len();
    rq.gw   = $urandom();
    rq.ifc  = IFB'($urandom());
    rq.dir  = 1'($urandom_range(0, 1));
    if (p < (filling ? 80 : 35)) begin
      rq.op = OP_ADD;
      // revisit a stored route: either an identical copy or a replacement
      if (s >= 0 && coin < (filling ? 15 : 45)) begin
        rq.dest = rt_pfx[s] | ($urandom() & ~prefix_mask(rt_len[s]));
        rq.plen = (rt_len[s] == LEN_W'(MAX_LEN) && coin[0]) ?
                  LEN_W'($urandom_range(MAX_LEN, 63)) : rt_len[s];
        if ($urandom_range(0, 1) == 1) begin
          rq.gw  = rt_gw[s];
          rq.ifc = rt_if[s];
          rq.dir = rt_dir[s];
        end
      end
    end else if (p < (filling ? 85 : 60)) begin
      rq.op = OP_DEL;
      if (s >= 0 && coin < 70) begin
        rq.dest = rt_pfx[s] | ($urandom() & ~prefix_mask(rt_len[s]));
        rq.plen = rt_len[s];
      end
    end else if (filling || p < 98) begin
      rq.op = OP_LOOKUP;
      if (s >= 0 && coin < 75) rq.dest = rt_pfx[s] | ($urandom() & ~prefix_mask(rt_len[s]));
    end else begin
      rq.op = OP_CLEAR;
    end
    return rq;
  endfunction

  task automatic plan_row(input op_t op, input logic [IP_W-1:0] dest,
                          input logic [LEN_W-1:0] plen, input logic [IP_W-1:0] gw,
                          input logic [IFB-1:0] ifc, input logic dir,
                          input bit typed, input status_t status);
    plan_row_t r;
    r.rq     = '{op: op, dest: dest, plen: plen, gw: gw, ifc: ifc, dir: dir};
    r.typed  = typed;
    r.status = status;
    plan.push_back(r);
  endtask

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("%0t ERROR: %s", $time, what);
  endtask

  // Offer one operation after a random gap, hold until the transfer, then record its result
  task automatic send_op(input route_req_t rq, input bit typed, input status_t typed_status);
    int unsigned gap;
    route_rsp_t  want;
    gap = (((ops_sent / 32) % 5) == 4) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.op            <= rq.op;
    req_bus.dest_ip       <= rq.dest;
    req_bus.prefix_len    <= rq.plen;
    req_bus.gateway_ip    <= rq.gw;
    req_bus.out_interface <= rq.ifc;
    req_bus.direct_route  <= rq.dir;
    do @(posedge clk); while (!req_bus.ready);
    want = route_table_apply(rq);
    if (typed) begin
      want        = '0;
      want.status = typed_status;
    end
    pending_results.push_back(want);
    ops_sent++;
    op_cnt[rq.op]++;
    status_cnt[want.status]++;
    if (want.hit) hit_cnt++;
  endtask

  task automatic check_result();
    route_rsp_t got;
    route_rsp_t want;
    got.status     = status_t'(rsp_bus.status);
    got.hit        = rsp_bus.hit;
    got.next_hop   = rsp_bus.next_hop;
    got.egress_if  = rsp_bus.egress_if;
    got.hit_direct = rsp_bus.hit_direct;
    got.match_len  = rsp_bus.match_len;
    results_seen++;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("result %0d arrived with no operation outstanding", results_seen));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      flag_error($sformatf("result %0d status: expected %0d, got %0d",
                           results_seen, want.status, got.status));
    if (got.hit !== want.hit)
      flag_error($sformatf("result %0d hit: expected %0b, got %0b",
                           results_seen, want.hit, got.hit));
    if (got.next_hop !== want.next_hop)
      flag_error($sformatf("result %0d next_hop: expected %08h, got %08h",
                           results_seen, want.next_hop, got.next_hop));
    if (got.egress_if !== want.egress_if)
      flag_error($sformatf("result %0d egress_if: expected %0d, got %0d",
                           results_seen, want.egress_if, got.egress_if));
    if (got.hit_direct !== want.hit_direct)
      flag_error($sformatf("result %0d hit_direct: expected %0b, got %0b",
                           results_seen, want.hit_direct, got.hit_direct));
    if (got.match_len !== want.match_len)
      flag_error($sformatf("result %0d match_len: expected %0d, got %0d",
                           results_seen, want.match_len, got.match_len));
  endtask

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d with %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, bursts of full readiness and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = (((results_seen / 32) % 5) == 2) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      check_result();
    end
  end

  // Request side: directed plan, then random traffic, then drain
  initial begin : stimulus
    bit filling;
    for (int i = 0; i < DEPTH; i++) rt_valid[i] = 1'b0;
    for (int i = 0; i < 4; i++) begin
      op_cnt[i]     = 0;
      status_cnt[i] = 0;
    end
    req_bus.valid         <= 1'b0;
    req_bus.op            <= OP_ADD;
    req_bus.dest_ip       <= '0;
    req_bus.prefix_len    <= '0;
    req_bus.gateway_ip    <= '0;
    req_bus.out_interface <= '0;
    req_bus.direct_route  <= 1'b0;

    //        op         dest          len    gateway       iface  dir
    // empty table: every lookup and delete misses
    plan_row(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 8'h00, 1'b0, TYPED, ST_NOT_FOUND);
    plan_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1'b1, TYPED, ST_NOT_FOUND);
    plan_row(OP_DEL,    32'h0A00_0000, 6'd8,  32'h0000_0000, 8'h00, 1'b0, TYPED, ST_NOT_FOUND);
    // host bits are masked off, so the second add is the same route
    plan_row(OP_ADD,    32'h0A0B_0C0D, 6'd8,  32'h0A00_0001, 8'h01, 1'b0, TYPED, ST_OK);
    plan_row(OP_ADD,    32'h0AFF_FFFF, 6'd8,  32'h0A00_0001, 8'h01, 1'b0, TYPED, ST_SAME);
    plan_row(OP_ADD,    32'h0A00_0000, 6'd8,  32'h0A00_00FE, 8'h01, 1'b0, PREDICTED, ST_OK);
    // default route, host route, over-long length and a direct route
    plan_row(OP_ADD,    32'h1234_5678, 6'd0,  32'hFFFF_FFFF, 8'hFF, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_ADD,    32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_ADD,    32'hC0A8_0101, 6'd63, 32'h8000_0001, 8'h80, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_ADD,    32'hC0A8_FFFF, 6'd16, 32'hDEAD_BEEF, 8'h7F, 1'b1, PREDICTED, ST_OK);
    // a direct route stores no gateway, so other gateway bits change nothing
    plan_row(OP_ADD,    32'hC0A8_0000, 6'd16, 32'h1234_5678, 8'h55, 1'b1, TYPED, ST_SAME);
    plan_row(OP_LOOKUP, 32'hC0A8_0101, 6'd0,  32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_LOOKUP, 32'hC0A8_0202, 6'd0,  32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_LOOKUP, 32'h0A0B_0C0D, 6'd32, 32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_LOOKUP, 32'h0102_0304, 6'd17, 32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    // delete with an over-long length hits the host route
    plan_row(OP_DEL,    32'hC0A8_0101, 6'd40, 32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_DEL,    32'hC0A8_0101, 6'd32, 32'h0000_0000, 8'h00, 1'b0, TYPED, ST_NOT_FOUND);
    plan_row(OP_LOOKUP, 32'hC0A8_0101, 6'd0,  32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_DEL,    32'h0000_0000, 6'd0,  32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    plan_row(OP_LOOKUP, 32'h0102_0304, 6'd0,  32'h0000_0000, 8'h00, 1'b0, PREDICTED, ST_OK);
    // clear, then the table is empty again
    plan_row(OP_CLEAR,  32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1'b1, TYPED, ST_OK);
    plan_row(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 8'h00, 1'b0, TYPED, ST_NOT_FOUND);
    plan_row(OP_DEL,    32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 8'h00, 1'b0, TYPED, ST_NOT_FOUND);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_op(plan[i].rq, plan[i].typed, plan[i].status);

    // fill, mix, fill again, then mix to the end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      filling = (n < 120) || (n >= 320 && n < 470);
      send_op(draw_request(filling), PREDICTED, ST_OK);
    end
    req_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d adds, %0d deletes, %0d lookups, %0d clears",
             ops_sent, op_cnt[OP_ADD], op_cnt[OP_DEL], op_cnt[OP_LOOKUP], op_cnt[OP_CLEAR]);
    $display("Saw %0d lookup hits, %0d identical adds, %0d full-table drops, %0d misses; %0d errors",
             hit_cnt, status_cnt[ST_SAME], status_cnt[ST_FULL], status_cnt[ST_NOT_FOUND],
             err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
